// ===== src/binomial_mod_prime_core_assert.svh =====
// Assertion macros shared by the binomial core.
`ifndef BINOMIAL_MOD_PRIME_CORE_ASSERT_SVH
`define BINOMIAL_MOD_PRIME_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BMP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bmp_pkg.sv =====
// Shared types and constants of the binomial coefficient core.
package bmp_pkg;

    localparam logic [29:0] PRIME      = 30'd1000000007;
    localparam logic [31:0] PRIME_X2   = 32'd2000000014;
    localparam logic [29:0] FERMAT_EXP = 30'd1000000005;
    localparam int          EXP_BITS   = 30;
    localparam int          EXP_BW     = 5;
    localparam logic [30:0] BARRETT_M  = 31'((64'd1 << 60) / 64'd1000000007);
    localparam int          MUL_LAT    = 4;
    localparam int          QUEUE_DEPTH = 4;
    localparam int          IDX_W      = 12;
    localparam int          ADDR_MAX_W = 18;

    typedef struct packed {
        logic [11:0] n_total;
        logic [11:0] k_chosen;
    } query_t;

    typedef struct packed {
        logic [29:0] binom_value;
        logic        out_of_range;
    } result_t;

    typedef struct packed {
        logic [IDX_W-1:0] n_idx;
        logic [IDX_W-1:0] nk_idx;
        logic [IDX_W-1:0] k_idx;
        logic             zero;
        logic             oor;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } queue_out_t;

    typedef struct packed {
        logic                  mul_go;
        logic [29:0]           mul_a;
        logic [29:0]           mul_b;
        logic                  wr_fact;
        logic                  wr_inv;
        logic [ADDR_MAX_W-1:0] wr_addr;
        logic [29:0]           wr_data;
    } fill_req_t;

    typedef struct packed {
        logic        valid;
        logic [29:0] y;
    } mul_ret_t;

    typedef enum logic [2:0] {
        FILL_INIT,
        FILL_FACT,
        FILL_POW,
        FILL_INV,
        FILL_DONE
    } fill_state_t;

endpackage

// ===== src/bmp_stream_if.sv =====
// Valid/ready channel carrying one payload item per transfer.
interface bmp_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/bmp_mulmod.sv =====
// Pipelined modular multiplier with Barrett reduction.
module bmp_mulmod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [29:0] a,
    input  logic [29:0] b,
    output logic        out_valid,
    output logic [29:0] y
);
    import bmp_pkg::*;

    logic [59:0]        prod_reg, prod_next;
    logic [61:0]        q2_reg, q2_next;
    logic [31:0]        plo_reg;
    logic [31:0]        r_reg, r_next;
    logic [29:0]        y_reg, y_next;
    logic [MUL_LAT-1:0] v_reg, v_next;
    logic [63:0]        qp;

    always_comb
    begin
        prod_next = {30'b0, a} * {30'b0, b};
        q2_next   = 62'(prod_reg[59:29]) * 62'(BARRETT_M);
        qp        = 64'(q2_reg[61:31]) * 64'(PRIME);
        // The Barrett estimate is short by at most two multiples of the prime.
        r_next    = plo_reg - qp[31:0];
        if (r_reg >= PRIME_X2)
        begin
            y_next = 30'(r_reg - PRIME_X2);
        end
        else if (r_reg >= 32'(PRIME))
        begin
            y_next = 30'(r_reg - 32'(PRIME));
        end
        else
        begin
            y_next = r_reg[29:0];
        end
        v_next = {v_reg[MUL_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            q2_reg   <= q2_next;
            plo_reg  <= prod_reg[31:0];
            r_reg    <= r_next;
            y_reg    <= y_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    assign out_valid = v_reg[MUL_LAT-1];
    assign y         = y_reg;
endmodule

// ===== src/bmp_front.sv =====
// Query intake: classifies each query and holds it in a short queue.
module bmp_front #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tables_ready,
    bmp_stream_if.sink          query,
    input  logic                pop,
    output bmp_pkg::queue_out_t head
);
    import bmp_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);

    job_t            queue_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QP_W:0]   count_reg, count_next;
    logic            push;
    job_t            job_in;

    always_comb
    begin
        job_in.n_idx  = query.data.n_total;
        job_in.k_idx  = query.data.k_chosen;
        job_in.nk_idx = query.data.n_total - query.data.k_chosen;
        job_in.oor    = (32'(query.data.n_total) >= TABLE_SIZE);
        job_in.zero   = job_in.oor || (query.data.k_chosen > query.data.n_total);
    end

    assign query.ready = tables_ready && (count_reg < (QP_W+1)'(QUEUE_DEPTH));
    assign push        = query.valid && query.ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QP_W+1)'(push) - (QP_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.job   = queue_reg[rd_ptr_reg];
endmodule

// ===== src/bmp_fill.sv =====
// Table fill sequencer: factorials, Fermat inverse of the top one, inverse recurrence.
module bmp_fill #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bmp_pkg::mul_ret_t  mul_ret,
    output bmp_pkg::fill_req_t req,
    output logic               tables_ready
);
    import bmp_pkg::*;

    localparam int           AW  = $clog2(TABLE_SIZE);
    localparam logic [AW-1:0] TOP = AW'(TABLE_SIZE - 1);

    fill_state_t       state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [29:0]       run_reg, run_next;
    logic [29:0]       acc_reg, acc_next;
    logic [EXP_BW-1:0] bit_reg, bit_next;
    logic              phase_reg, phase_next;
    logic              pend_reg, pend_next;
    logic              pow_last;

    // The last product of the exponentiation is a square or multiply at bit zero.
    assign pow_last = !(!phase_reg && FERMAT_EXP[bit_reg]) && (bit_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FILL_INIT: state_next = FILL_FACT;
            FILL_FACT:
            begin
                if (mul_ret.valid && idx_reg == TOP)
                begin
                    state_next = FILL_POW;
                end
            end
            FILL_POW:
            begin
                if (mul_ret.valid && pow_last)
                begin
                    state_next = FILL_INV;
                end
            end
            FILL_INV:
            begin
                if (mul_ret.valid && idx_reg == AW'(1))
                begin
                    state_next = FILL_DONE;
                end
            end
            FILL_DONE: state_next = FILL_DONE;
            default:   state_next = FILL_INIT;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        run_next   = run_reg;
        acc_next   = acc_reg;
        bit_next   = bit_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        case (state_reg)
            FILL_INIT:
            begin
                idx_next  = AW'(1);
                run_next  = 30'd1;
                pend_next = 1'b0;
            end
            FILL_FACT:
            begin
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                end
                if (mul_ret.valid)
                begin
                    pend_next = 1'b0;
                    run_next  = mul_ret.y;
                    if (idx_reg == TOP)
                    begin
                        acc_next   = 30'd1;
                        bit_next   = EXP_BW'(EXP_BITS - 1);
                        phase_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            FILL_POW:
            begin
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                end
                if (mul_ret.valid)
                begin
                    pend_next = 1'b0;
                    acc_next  = mul_ret.y;
                    if (!phase_reg && FERMAT_EXP[bit_reg])
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        if (bit_reg == '0)
                        begin
                            run_next = mul_ret.y;
                        end
                        else
                        begin
                            bit_next = bit_reg - 1'b1;
                        end
                    end
                end
            end
            FILL_INV:
            begin
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                end
                if (mul_ret.valid)
                begin
                    pend_next = 1'b0;
                    run_next  = mul_ret.y;
                    idx_next  = idx_reg - 1'b1;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        req         = '0;
        req.wr_data = mul_ret.y;
        req.wr_addr = ADDR_MAX_W'(idx_reg);
        case (state_reg)
            FILL_INIT:
            begin
                req.wr_fact = 1'b1;
                req.wr_addr = '0;
                req.wr_data = 30'd1;
            end
            FILL_FACT:
            begin
                req.mul_go  = !pend_reg;
                req.mul_a   = run_reg;
                req.mul_b   = 30'(idx_reg);
                req.wr_fact = mul_ret.valid;
            end
            FILL_POW:
            begin
                req.mul_go = !pend_reg;
                req.mul_a  = acc_reg;
                req.mul_b  = phase_reg ? run_reg : acc_reg;
                req.wr_inv = mul_ret.valid && pow_last;
            end
            FILL_INV:
            begin
                req.mul_go  = !pend_reg;
                req.mul_a   = run_reg;
                req.mul_b   = 30'(idx_reg);
                req.wr_inv  = mul_ret.valid;
                req.wr_addr = ADDR_MAX_W'(idx_reg - 1'b1);
            end
            default:
            begin
                req.mul_go = 1'b0;
            end
        endcase
    end

    assign tables_ready = (state_reg == FILL_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FILL_INIT;
            pend_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        run_reg <= run_next;
        acc_reg <= acc_next;
        bit_reg <= bit_next;
    end
endmodule

// ===== src/bmp_back.sv =====
// Execution: table memories, two chained mulmods (first also fills), output register.
module bmp_back #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tables_ready,
    input  bmp_pkg::queue_out_t head,
    output logic                pop,
    input  bmp_pkg::fill_req_t  fill_req,
    output bmp_pkg::mul_ret_t   mul_ret,
    bmp_stream_if.source        result
);
    import bmp_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);

    logic [29:0] fact_table_reg [TABLE_SIZE];
    logic [29:0] inv_table_reg  [TABLE_SIZE];

    logic        adv;
    logic [29:0] fact_rd_reg, inv_nk_rd_reg, inv_k_rd_reg;
    logic        sa_valid_reg, sa_valid_next;
    logic        sa_zero_reg, sa_oor_reg;

    logic [29:0] d1_invk_reg [MUL_LAT];
    logic        d1_zero_reg [MUL_LAT];
    logic        d1_oor_reg  [MUL_LAT];
    logic        d2_zero_reg [MUL_LAT];
    logic        d2_oor_reg  [MUL_LAT];

    logic        m1_en, m1_in_valid, m1_valid, m2_valid, m2_in_valid;
    logic [29:0] m1_a, m1_b, m1_y, m2_y;

    logic        out_valid_reg, out_valid_next;
    logic [29:0] out_value_reg;
    logic        out_oor_reg;

    // The whole query pipeline moves only when the output register can take a result.
    assign adv = !out_valid_reg || result.ready;
    assign pop = adv && head.valid && tables_ready;

    always_ff @(posedge clk)
    begin
        if (fill_req.wr_fact)
        begin
            fact_table_reg[AW'(fill_req.wr_addr)] <= fill_req.wr_data;
        end
        if (adv)
        begin
            fact_rd_reg <= fact_table_reg[AW'(head.job.n_idx)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_req.wr_inv)
        begin
            inv_table_reg[AW'(fill_req.wr_addr)] <= fill_req.wr_data;
        end
        if (adv)
        begin
            inv_nk_rd_reg <= inv_table_reg[AW'(head.job.nk_idx)];
            inv_k_rd_reg  <= inv_table_reg[AW'(head.job.k_idx)];
        end
    end

    always_comb
    begin
        sa_valid_next  = adv ? pop : sa_valid_reg;
        out_valid_next = adv ? m2_valid : out_valid_reg;
        m1_en          = tables_ready ? adv : 1'b1;
        m1_in_valid    = tables_ready ? sa_valid_reg : fill_req.mul_go;
        m1_a           = tables_ready ? fact_rd_reg : fill_req.mul_a;
        m1_b           = tables_ready ? inv_nk_rd_reg : fill_req.mul_b;
        m2_in_valid    = m1_valid && tables_ready;
    end

    bmp_mulmod u_mul1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (m1_en),
        .in_valid  (m1_in_valid),
        .a         (m1_a),
        .b         (m1_b),
        .out_valid (m1_valid),
        .y         (m1_y)
    );

    bmp_mulmod u_mul2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (m2_in_valid),
        .a         (m1_y),
        .b         (d1_invk_reg[MUL_LAT-1]),
        .out_valid (m2_valid),
        .y         (m2_y)
    );

    assign mul_ret.valid = m1_valid;
    assign mul_ret.y     = m1_y;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_zero_reg    <= head.job.zero;
            sa_oor_reg     <= head.job.oor;
            d1_invk_reg[0] <= inv_k_rd_reg;
            d1_zero_reg[0] <= sa_zero_reg;
            d1_oor_reg[0]  <= sa_oor_reg;
            d2_zero_reg[0] <= d1_zero_reg[MUL_LAT-1];
            d2_oor_reg[0]  <= d1_oor_reg[MUL_LAT-1];
            for (int i = 1; i < MUL_LAT; i++)
            begin
                d1_invk_reg[i] <= d1_invk_reg[i-1];
                d1_zero_reg[i] <= d1_zero_reg[i-1];
                d1_oor_reg[i]  <= d1_oor_reg[i-1];
                d2_zero_reg[i] <= d2_zero_reg[i-1];
                d2_oor_reg[i]  <= d2_oor_reg[i-1];
            end
            out_value_reg <= d2_zero_reg[MUL_LAT-1] ? 30'd0 : m2_y;
            out_oor_reg   <= d2_oor_reg[MUL_LAT-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sa_valid_reg  <= sa_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.data.binom_value  = out_value_reg;
    assign result.data.out_of_range = out_oor_reg;
endmodule

// ===== src/binomial_mod_prime_core.sv =====
// Top level of the binomial coefficient modulo 1000000007 core.
// After reset the core fills a factorial table and an inverse-factorial table of
// TABLE_SIZE entries, one modular product at a time through the four-stage
// multiplier, and no query transfer is taken until the fill ends. After that the
// core takes one query (n, k) per cycle while the queue has room and results are
// taken, and offers C(n,k) mod p after a queue stage, a table read, two chained
// four-stage modular multipliers and the output register. A result is 0 when k
// exceeds n, and 0 with out_of_range set when n is at or beyond TABLE_SIZE.
// A four-entry queue sits between intake and execution.
`include "binomial_mod_prime_core_assert.svh"

module binomial_mod_prime_core #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    bmp_stream_if.sink   query,
    bmp_stream_if.source result
);
    import bmp_pkg::*;

    logic       tables_ready;
    logic       pop;
    queue_out_t head;
    fill_req_t  fill_req;
    mul_ret_t   mul_ret;

    bmp_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .tables_ready (tables_ready),
        .query        (query),
        .pop          (pop),
        .head         (head)
    );

    bmp_fill #(.TABLE_SIZE(TABLE_SIZE)) u_fill (
        .clk          (clk),
        .rst_n        (rst_n),
        .mul_ret      (mul_ret),
        .req          (fill_req),
        .tables_ready (tables_ready)
    );

    bmp_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tables_ready (tables_ready),
        .head         (head),
        .pop          (pop),
        .fill_req     (fill_req),
        .mul_ret      (mul_ret),
        .result       (result)
    );

    `BMP_ASSERT_SAME(a_no_query_during_fill, clk, rst_n, query.valid && query.ready, tables_ready, "query taken before tables were filled")
    `BMP_ASSERT_NEXT(a_ready_sticks, clk, rst_n, tables_ready, tables_ready, "tables_ready dropped after fill")
    `BMP_ASSERT_SAME(a_oor_zero, clk, rst_n, result.valid && result.data.out_of_range, result.data.binom_value == 30'd0, "out of range result is not zero")
    `BMP_ASSERT_SAME(a_value_reduced, clk, rst_n, result.valid, result.data.binom_value < PRIME, "result not reduced modulo the prime")
endmodule
